// ----- rtl/core/cle_pkg.sv -----
// cle_pkg: shared types and codes for the contiguous list engine.
// Used by cle_cell and contiguous_list_engine; depends on nothing.
package cle_pkg;

   // Command codes of an incoming word.
   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_DELETE = 3'd1;
   localparam logic [2:0] CMD_READ   = 3'd2;
   localparam logic [2:0] CMD_WRITE  = 3'd3;
   localparam logic [2:0] CMD_SEARCH = 3'd4;
   localparam logic [2:0] CMD_SORT   = 3'd5;

   // Status codes of a result word.
   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_RANGE = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_INSERT,
      OP_DELETE,
      OP_WRITE,
      OP_SORT
   } cell_op_type;

   typedef enum logic {
      ST_READY,
      ST_SORT
   } state_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [4:0]         position;
      logic signed [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               found;
      logic [3:0]         found_index;
      logic [1:0]         status;
      logic [4:0]         count;
   } rsp_word_type;

   // Broadcast from the control logic to every cell.
   typedef struct packed {
      cell_op_type        op;
      logic [4:0]         position;
      logic [31:0]        value;
      logic               phase;
   } cell_ctl_type;

endpackage

// ----- rtl/core/cle_cell.sv -----
// cle_cell: one list entry of the contiguous list engine chain.
// Depends on cle_pkg.
module cle_cell #(
   parameter int WIDTH = 32,
   parameter int CW    = 5,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  cle_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]         count,
   input  logic [WIDTH-1:0]      left_data,
   input  logic [WIDTH-1:0]      right_data,
   output logic [WIDTH-1:0]      data,
   output logic                  match
);

   localparam logic PAR = 1'(INDEX % 2);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;
   logic [WIDTH-1:0] key;
   int               pos_i;
   int               cnt_i;

   // incoming word value, zero extended or cut to the entry width
   generate
      if (WIDTH >= 32) begin : g_wide
         assign key = WIDTH'(ctl.value);
      end else begin : g_narrow
         assign key = ctl.value[WIDTH-1:0];
      end
   endgenerate

   assign pos_i = int'(ctl.position);
   assign cnt_i = int'(count);

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         cle_pkg::OP_INSERT: begin
            if (INDEX == pos_i) begin
               data_in = key;
            end else if (INDEX > pos_i && INDEX <= cnt_i) begin
               data_in = left_data;
            end
         end
         cle_pkg::OP_DELETE: begin
            if (INDEX >= pos_i && INDEX + 1 < cnt_i) begin
               data_in = right_data;
            end
         end
         cle_pkg::OP_WRITE: begin
            if (INDEX == pos_i) begin
               data_in = key;
            end
         end
         cle_pkg::OP_SORT: begin
            // odd-even transposition: lower cell of a pair keeps the larger
            if (PAR == ctl.phase) begin
               if (INDEX + 1 < cnt_i && $signed(data_ff) < $signed(right_data)) begin
                  data_in = right_data;
               end
            end else if (INDEX > 0 && INDEX < cnt_i) begin
               if ($signed(left_data) < $signed(data_ff)) begin
                  data_in = left_data;
               end
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (data_ff == key) && (INDEX < cnt_i);

endmodule

// ----- rtl/core/contiguous_list_engine.sv -----
// contiguous_list_engine: packed ordered list of signed words with a count.
// Depends on cle_pkg and cle_cell.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | cle_pkg::req_word_type
//   rsp     | out       | rsp_valid/rsp_stall | cle_pkg::rsp_word_type
//
// Insert, delete, read, write and search finish in the cycle the word is
// taken; the result is registered in the output register, so such words
// flow at one per cycle while the result is not stalled. Sort runs DEPTH
// odd-even transposition steps through the cell chain, input stalled.
// Reset (synchronous) empties the list; entry contents are not cleared.
// A stalled result holds the input off only until it is taken.
module contiguous_list_engine #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cle_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cle_pkg::rsp_word_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int PW = (CW > 5) ? CW : 5;

   cle_pkg::state_type    state_ff, state_in;
   logic [IW-1:0]         step_ff, step_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cle_pkg::rsp_word_type rsp_ff, rsp_in;

   cle_pkg::cell_ctl_type ctl;
   cle_pkg::cell_op_type  op_req;
   logic                  accept;
   logic                  sort_go;
   logic [CW-1:0]         count_calc;
   logic [PW-1:0]         pos_x;
   logic [PW-1:0]         cnt_x;
   logic [WIDTH-1:0]      cell_data [DEPTH];
   logic [DEPTH-1:0]      match;
   logic [IW-1:0]         hit_idx;
   logic [WIDTH-1:0]      rd_word;

   assign accept = req_valid && !req_stall;
   assign pos_x  = PW'(req_data.position);
   assign cnt_x  = PW'(count_ff);

   // ---- cell chain ----
   generate
      for (genvar g = 0; g < DEPTH; g++) begin : g_cell
         logic [WIDTH-1:0] left_w;
         logic [WIDTH-1:0] right_w;
         if (g == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_left
            assign left_w = cell_data[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_right
            assign right_w = cell_data[g+1];
         end
         cle_cell #(
            .WIDTH(WIDTH),
            .CW   (CW),
            .INDEX(g)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .count     (count_ff),
            .left_data (left_w),
            .right_data(right_w),
            .data      (cell_data[g]),
            .match     (match[g])
         );
      end
   endgenerate

   // lowest matching entry
   always_comb begin
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IW'(i);
         end
      end
   end

   assign rd_word = cell_data[IW'(req_data.position)];

   // ---- command decode and result ----
   always_comb begin
      op_req     = cle_pkg::OP_NOP;
      sort_go    = 1'b0;
      count_calc = count_ff;
      rsp_in     = '0;
      case (req_data.cmd)
         cle_pkg::CMD_INSERT: begin
            if (pos_x > cnt_x) begin
               rsp_in.status = cle_pkg::STS_RANGE;
            end else if (cnt_x == PW'(DEPTH)) begin
               rsp_in.status = cle_pkg::STS_FULL;
            end else begin
               op_req     = cle_pkg::OP_INSERT;
               count_calc = count_ff + 1'b1;
            end
         end
         cle_pkg::CMD_DELETE: begin
            if (pos_x >= cnt_x) begin
               rsp_in.status = cle_pkg::STS_RANGE;
            end else begin
               op_req     = cle_pkg::OP_DELETE;
               count_calc = count_ff - 1'b1;
            end
         end
         cle_pkg::CMD_READ: begin
            if (pos_x >= cnt_x) begin
               rsp_in.status = cle_pkg::STS_RANGE;
            end else begin
               rsp_in.read_value = $signed(32'(rd_word));
            end
         end
         cle_pkg::CMD_WRITE: begin
            if (pos_x >= cnt_x) begin
               rsp_in.status = cle_pkg::STS_RANGE;
            end else begin
               op_req = cle_pkg::OP_WRITE;
            end
         end
         cle_pkg::CMD_SEARCH: begin
            if (|match) begin
               rsp_in.found       = 1'b1;
               rsp_in.found_index = 4'(hit_idx);
            end
         end
         cle_pkg::CMD_SORT: begin
            sort_go = 1'b1;
         end
         default: begin
            op_req = cle_pkg::OP_NOP;
         end
      endcase
      rsp_in.count = 5'(count_calc);
   end

   assign count_in     = accept ? count_calc : count_ff;
   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // ---- sort sequencer: next state ----
   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      case (state_ff)
         cle_pkg::ST_READY: begin
            if (accept && sort_go) begin
               state_in = cle_pkg::ST_SORT;
            end
         end
         cle_pkg::ST_SORT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == IW'(DEPTH - 1)) begin
               state_in = cle_pkg::ST_READY;
               step_in  = '0;
            end
         end
         default: begin
            state_in = cle_pkg::ST_READY;
         end
      endcase
   end

   // ---- sort sequencer: outputs ----
   always_comb begin
      ctl.position = req_data.position;
      ctl.value    = req_data.value;
      ctl.phase    = step_ff[0];
      ctl.op       = cle_pkg::OP_NOP;
      req_stall    = rsp_valid_ff && rsp_stall;
      case (state_ff)
         cle_pkg::ST_READY: begin
            if (accept) begin
               ctl.op = op_req;
            end
         end
         cle_pkg::ST_SORT: begin
            ctl.op    = cle_pkg::OP_SORT;
            req_stall = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cle_pkg::ST_READY;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
